>>> rtl/dnsp_pkg.sv
// Shared types and constants of the DNS response parser.
// Used by the controller, the datapath and the result stage; depends on nothing.
`default_nettype none

package dnsp_pkg;

  localparam int NAME_CHARS  = 255;
  localparam int HOP_LIMIT   = 16;
  localparam int CHUNK_CHARS = 8;
  localparam int MAX_RESULTS = 34;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_PARSE,
    OP_FLAG,
    OP_NAME_END,
    OP_WALK,
    OP_WALK_LEN,
    OP_WALK_PTR,
    OP_CHR,
    OP_CHR_DATA,
    OP_EOM
  } op_e;

  typedef enum logic [2:0] {
    C_DONE,
    C_FLAGS,
    C_NAME_END,
    C_WALK,
    C_WALK_LEN,
    C_WALK_PTR,
    C_CHR,
    C_CHR_DATA
  } cont_e;

  typedef struct packed {
    op_e        op;
    logic [2:0] fidx;
  } cmd_t;

  typedef struct packed {
    cont_e cont;
    logic  eom;
  } status_t;

  typedef struct packed {
    logic [4:0]  kind;
    logic [63:0] value;
    logic [3:0]  chars;
    logic        ans;
    logic [15:0] idx;
    logic [1:0]  err;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/dnsp_out.sv
// Result stage: a pending word and an output register with valid/ready.
// Marks the last word of a byte when closed; uses dnsp_pkg.
`default_nettype none

module dnsp_out (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire dnsp_pkg::res_t res_i,
  input  wire logic          close_i,
  output logic               can_push_o,
  output logic               pend_v_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output dnsp_pkg::res_t     out_res_o,
  output logic               out_last_o
);

  logic           pend_v_q;
  logic           out_v_q;
  dnsp_pkg::res_t pend_q;
  dnsp_pkg::res_t out_q;
  logic           last_q;
  logic           out_free;
  logic           do_close;

  assign out_free   = !out_v_q || out_ready_i;
  assign can_push_o = !pend_v_q || out_free;
  assign do_close   = !push_i && close_i && pend_v_q && out_free;
  assign pend_v_o   = pend_v_q;
  assign out_valid_o = out_v_q;
  assign out_res_o  = out_q;
  assign out_last_o = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (push_i) begin
        out_v_q  <= pend_v_q || (out_v_q && !out_ready_i);
        pend_v_q <= 1'b1;
      end else if (do_close) begin
        out_v_q  <= 1'b1;
        pend_v_q <= 1'b0;
      end else if (out_v_q && out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      if (pend_v_q) begin
        out_q  <= pend_q;
        last_q <= 1'b0;
      end
      pend_q <= res_i;
    end else if (do_close) begin
      out_q  <= pend_q;
      last_q <= 1'b1;
    end
  end

  a_push_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> can_push_o) else $error("word pushed into a full result stage");
  a_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !can_push_o |-> (pend_v_q && out_v_q)) else $error("result stage blocked while free");
  a_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_close |=> (!pend_v_q && out_v_q && last_q)) else $error("close did not move word");

endmodule

`default_nettype wire

>>> rtl/dnsp_ctrl.sv
// Controller state machine of the DNS response parser.
// Sequences datapath operations per byte; uses dnsp_pkg.
`default_nettype none

module dnsp_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic             can_push_i,
  input  wire logic             pend_v_i,
  input  wire dnsp_pkg::status_t status_i,
  output dnsp_pkg::cmd_t        cmd_o,
  output logic                  close_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_PARSE, S_FLAGS, S_NAME_END, S_WALK, S_WALK_LEN, S_WALK_PTR,
    S_CHR, S_CHR_DATA, S_EOM, S_CLOSE
  } state_e;

  state_e     state_q, state_d;
  logic [2:0] fidx_q, fidx_d;
  state_e     done_st;
  state_e     cont_st;

  assign done_st = status_i.eom ? S_EOM : S_CLOSE;

  always_comb begin
    unique case (status_i.cont)
      dnsp_pkg::C_FLAGS:    cont_st = S_FLAGS;
      dnsp_pkg::C_NAME_END: cont_st = S_NAME_END;
      dnsp_pkg::C_WALK:     cont_st = S_WALK;
      dnsp_pkg::C_WALK_LEN: cont_st = S_WALK_LEN;
      dnsp_pkg::C_WALK_PTR: cont_st = S_WALK_PTR;
      dnsp_pkg::C_CHR:      cont_st = S_CHR;
      dnsp_pkg::C_CHR_DATA: cont_st = S_CHR_DATA;
      default:              cont_st = done_st;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    fidx_d      = fidx_q;
    cmd_o.op    = dnsp_pkg::OP_NONE;
    cmd_o.fidx  = fidx_q;
    in_ready_o  = 1'b0;
    close_o     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = dnsp_pkg::OP_LOAD;
          state_d  = S_PARSE;
        end
      end
      S_CLOSE: begin
        close_o = 1'b1;
        if (!pend_v_i || can_push_i) state_d = S_IDLE;
      end
      default: begin
        if (can_push_i) begin
          unique case (state_q)
            S_PARSE: begin
              cmd_o.op = dnsp_pkg::OP_PARSE;
              state_d  = cont_st;
              fidx_d   = 3'd1;
            end
            S_FLAGS: begin
              cmd_o.op = dnsp_pkg::OP_FLAG;
              if (fidx_q == 3'd6) state_d = done_st;
              else fidx_d = fidx_q + 3'd1;
            end
            S_NAME_END: begin
              cmd_o.op = dnsp_pkg::OP_NAME_END;
              state_d  = done_st;
            end
            S_WALK: begin
              cmd_o.op = dnsp_pkg::OP_WALK;
              state_d  = cont_st;
            end
            S_WALK_LEN: begin
              cmd_o.op = dnsp_pkg::OP_WALK_LEN;
              state_d  = cont_st;
            end
            S_WALK_PTR: begin
              cmd_o.op = dnsp_pkg::OP_WALK_PTR;
              state_d  = cont_st;
            end
            S_CHR: begin
              cmd_o.op = dnsp_pkg::OP_CHR;
              state_d  = cont_st;
            end
            S_CHR_DATA: begin
              cmd_o.op = dnsp_pkg::OP_CHR_DATA;
              state_d  = cont_st;
            end
            default: begin
              cmd_o.op = dnsp_pkg::OP_EOM;
              state_d  = S_CLOSE;
            end
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fidx_q  <= 3'd1;
    end else begin
      state_q <= state_d;
      fidx_q  <= fidx_d;
    end
  end

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_PARSE)) else $error("byte not parsed");
  a_op_gated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE && state_q != S_CLOSE && !can_push_i) |=> $stable(state_q))
    else $error("step taken while result stage full");
  a_flag_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FLAGS) |-> (fidx_q != 3'd0 && fidx_q != 3'd7)) else $error("flag index");

endmodule

`default_nettype wire

>>> rtl/dnsp_dp.sv
// Datapath of the DNS response parser: message memory, parse registers,
// name chunk assembly and pointer walk. Uses dnsp_pkg.
`default_nettype none

module dnsp_dp #(
  parameter int MESSAGE_BYTES = 512
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire dnsp_pkg::cmd_t   cmd_i,
  input  wire logic [7:0]       data_byte_i,
  input  wire logic             end_of_message_i,
  output dnsp_pkg::status_t     status_o,
  output logic                  push_o,
  output dnsp_pkg::res_t        res_o
);

  localparam int AW = $clog2(MESSAGE_BYTES);
  localparam int PW = $clog2(MESSAGE_BYTES + 1);

  localparam logic [4:0] PH_NAME     = 5'd12;
  localparam logic [4:0] PH_LABEL    = 5'd13;
  localparam logic [4:0] PH_PTR_LO   = 5'd14;
  localparam logic [4:0] PH_TYPE_HI  = 5'd15;
  localparam logic [4:0] PH_TYPE_LO  = 5'd16;
  localparam logic [4:0] PH_CLASS_HI = 5'd17;
  localparam logic [4:0] PH_CLASS_LO = 5'd18;
  localparam logic [4:0] PH_TTL0     = 5'd19;
  localparam logic [4:0] PH_TTL3     = 5'd22;
  localparam logic [4:0] PH_RDLEN_HI = 5'd23;
  localparam logic [4:0] PH_RDLEN_LO = 5'd24;
  localparam logic [4:0] PH_RDATA    = 5'd25;
  localparam logic [4:0] PH_FINISHED = 5'd26;
  localparam logic [4:0] PH_ERROR    = 5'd27;

  localparam logic [4:0] K_ID       = 5'd0;
  localparam logic [4:0] K_QR       = 5'd1;
  localparam logic [4:0] K_CHUNK    = 5'd12;
  localparam logic [4:0] K_NAME_END = 5'd13;
  localparam logic [4:0] K_TYPE     = 5'd14;
  localparam logic [4:0] K_CLASS    = 5'd15;
  localparam logic [4:0] K_TTL      = 5'd16;
  localparam logic [4:0] K_LENGTH   = 5'd17;
  localparam logic [4:0] K_DATA     = 5'd18;
  localparam logic [4:0] K_DONE     = 5'd19;
  localparam logic [4:0] K_ERROR    = 5'd20;

  localparam logic [1:0] E_TRUNC    = 2'd1;
  localparam logic [1:0] E_POINTER  = 2'd2;
  localparam logic [1:0] E_TOO_LONG = 2'd3;

  logic [7:0] mem [MESSAGE_BYTES];

  logic [PW-1:0] pos_q, pos_d, sb_q, sb_d, wlim_q, wlim_d;
  logic [4:0]    phase_q, phase_d;
  logic [31:0]   acc_q, acc_d;
  logic [15:0]   ql_q, ql_d, al_q, al_d, cur_q, cur_d, dbl_q, dbl_d;
  logic [7:0]    lbl_q, lbl_d, nl_q, nl_d, byte_q, byte_d, wlen_q, wlen_d;
  logic          first_q, first_d, eom_q, eom_d;
  logic [5:0]    phh_q, phh_d, wk_q, wk_d, cnt_q, cnt_d;
  logic [63:0]   chunk_q, chunk_d, nb;
  logic [3:0]    fill_q, fill_d, nf;
  logic [15:0]   wt_q, wt_d, wlim_x, v16;
  logic [6:0]    hops_q, hops_d;
  logic [7:0]    rdata_q, add_c;
  logic          rd_en;
  logic [AW-1:0] raddr;
  logic          want, do_add, do_err, do_end, do_start, do_flush, ac_ok;
  logic [1:0]    err_code;
  dnsp_pkg::res_t r;
  dnsp_pkg::cont_e cont;

  assign v16    = {acc_q[7:0], byte_q};
  assign wlim_x = 16'(wlim_q);
  assign ac_ok  = nl_q < 8'(dnsp_pkg::NAME_CHARS);

  always_comb begin
    pos_d = pos_q; sb_d = sb_q; wlim_d = wlim_q; phase_d = phase_q; acc_d = acc_q;
    ql_d = ql_q; al_d = al_q; cur_d = cur_q; dbl_d = dbl_q; lbl_d = lbl_q;
    nl_d = nl_q; byte_d = byte_q; wlen_d = wlen_q; first_d = first_q; eom_d = eom_q;
    phh_d = phh_q; wk_d = wk_q; cnt_d = cnt_q; chunk_d = chunk_q; fill_d = fill_q;
    wt_d = wt_q; hops_d = hops_q;
    nb = chunk_q; nf = fill_q;
    rd_en = 1'b0; raddr = '0; want = 1'b0; r = '0; add_c = 8'h2e;
    do_add = 1'b0; do_err = 1'b0; do_end = 1'b0; do_start = 1'b0; do_flush = 1'b0;
    err_code = E_POINTER; cont = dnsp_pkg::C_DONE;
    r.ans = (ql_q == 16'd0);
    r.idx = cur_q;

    unique case (cmd_i.op)
      dnsp_pkg::OP_LOAD: begin
        byte_d = data_byte_i;
        eom_d  = end_of_message_i;
        sb_d   = pos_q;
        cnt_d  = '0;
        if (pos_q < PW'(MESSAGE_BYTES)) pos_d = pos_q + PW'(1);
      end
      dnsp_pkg::OP_PARSE: begin
        if (phase_q < PH_NAME) begin
          phase_d = phase_q + 5'd1;
          if (!phase_q[0]) begin
            acc_d = {24'd0, byte_q};
          end else begin
            want = 1'b1;
            r.ans = 1'b0;
            r.idx = '0;
            r.value = {48'd0, v16};
            priority if (phase_q == 5'd1) begin
              r.kind = K_ID;
            end else if (phase_q == 5'd3) begin
              r.kind  = K_QR;
              r.value = {63'd0, v16[15]};
              cont    = dnsp_pkg::C_FLAGS;
            end else begin
              r.kind = {1'b0, phase_q[4:1]} + 5'd6;
            end
            if (phase_q == 5'd5) ql_d = v16;
            if (phase_q == 5'd7) al_d = v16;
            if (phase_q == 5'd11) begin
              cur_d    = '0;
              do_start = 1'b1;
            end
          end
        end else begin
          case (phase_q)
            PH_NAME: begin
              if (byte_q == 8'd0) begin
                do_flush = 1'b1;
                cont     = dnsp_pkg::C_NAME_END;
              end else if (byte_q >= 8'hc0) begin
                phh_d   = byte_q[5:0];
                acc_d   = 32'(sb_q);
                phase_d = PH_PTR_LO;
              end else if (byte_q >= 8'h40) begin
                do_err = 1'b1;
              end else if (!first_q && !ac_ok) begin
                do_err   = 1'b1;
                err_code = E_TOO_LONG;
              end else begin
                do_add  = !first_q;
                first_d = 1'b0;
                lbl_d   = byte_q;
                phase_d = PH_LABEL;
              end
            end
            PH_LABEL: begin
              if (!ac_ok) begin
                do_err   = 1'b1;
                err_code = E_TOO_LONG;
              end else begin
                do_add = 1'b1;
                add_c  = byte_q;
                lbl_d  = lbl_q - 8'd1;
                if (lbl_q == 8'd1) phase_d = PH_NAME;
              end
            end
            PH_PTR_LO: begin
              wt_d   = {2'b00, phh_q, byte_q};
              wlim_d = acc_q[PW-1:0];
              hops_d = 7'd1;
              cont   = dnsp_pkg::C_WALK;
            end
            PH_TYPE_HI, PH_CLASS_HI, PH_RDLEN_HI: begin
              acc_d   = {24'd0, byte_q};
              phase_d = phase_q + 5'd1;
            end
            PH_TYPE_LO: begin
              want    = 1'b1;
              r.kind  = K_TYPE;
              r.value = {48'd0, v16};
              phase_d = PH_CLASS_HI;
            end
            PH_CLASS_LO: begin
              want    = 1'b1;
              r.kind  = K_CLASS;
              r.value = {48'd0, v16};
              if (ql_q != 16'd0) begin
                do_end = 1'b1;
              end else begin
                acc_d   = '0;
                phase_d = PH_TTL0;
              end
            end
            PH_RDLEN_LO: begin
              want    = 1'b1;
              r.kind  = K_LENGTH;
              r.value = {48'd0, v16};
              dbl_d   = v16;
              if (v16 == 16'd0) do_end = 1'b1;
              else phase_d = PH_RDATA;
            end
            PH_RDATA: begin
              want    = 1'b1;
              r.kind  = K_DATA;
              r.value = {56'd0, byte_q};
              dbl_d   = dbl_q - 16'd1;
              if (dbl_q == 16'd1) do_end = 1'b1;
            end
            default: begin
              if (phase_q >= PH_TTL0 && phase_q <= PH_TTL3) begin
                acc_d = {acc_q[23:0], byte_q};
                if (phase_q == PH_TTL3) begin
                  want    = 1'b1;
                  r.kind  = K_TTL;
                  r.value = {32'd0, acc_q[23:0], byte_q};
                  phase_d = PH_RDLEN_HI;
                end else begin
                  phase_d = phase_q + 5'd1;
                end
              end
            end
          endcase
        end
      end
      dnsp_pkg::OP_FLAG: begin
        want   = 1'b1;
        r.ans  = 1'b0;
        r.idx  = '0;
        r.kind = {2'b00, cmd_i.fidx} + 5'd1;
        unique case (cmd_i.fidx)
          3'd1:    r.value = {60'd0, v16[14:11]};
          3'd2:    r.value = {63'd0, v16[10]};
          3'd3:    r.value = {63'd0, v16[9]};
          3'd4:    r.value = {63'd0, v16[8]};
          3'd5:    r.value = {63'd0, v16[7]};
          default: r.value = {60'd0, v16[3:0]};
        endcase
      end
      dnsp_pkg::OP_NAME_END: begin
        want    = 1'b1;
        r.kind  = K_NAME_END;
        r.value = {56'd0, nl_q};
        phase_d = PH_TYPE_HI;
      end
      dnsp_pkg::OP_WALK: begin
        if (wt_q >= wlim_x) begin
          do_err = 1'b1;
        end else begin
          rd_en = 1'b1;
          raddr = wt_q[AW-1:0];
          cont  = dnsp_pkg::C_WALK_LEN;
        end
      end
      dnsp_pkg::OP_WALK_LEN: begin
        if (rdata_q >= 8'hc0) begin
          if (wt_q + 16'd1 >= wlim_x) begin
            do_err = 1'b1;
          end else if (hops_q + 7'd1 > 7'(dnsp_pkg::HOP_LIMIT)) begin
            do_err = 1'b1;
          end else begin
            hops_d = hops_q + 7'd1;
            wlen_d = rdata_q;
            rd_en  = 1'b1;
            raddr  = AW'(wt_q + 16'd1);
            cont   = dnsp_pkg::C_WALK_PTR;
          end
        end else if (rdata_q >= 8'h40) begin
          do_err = 1'b1;
        end else if (rdata_q == 8'd0) begin
          do_flush = 1'b1;
          cont     = dnsp_pkg::C_NAME_END;
        end else if (wt_q + 16'(rdata_q) >= wlim_x) begin
          do_err = 1'b1;
        end else if (!first_q && !ac_ok) begin
          do_err   = 1'b1;
          err_code = E_TOO_LONG;
        end else begin
          do_add  = !first_q;
          first_d = 1'b0;
          wlen_d  = rdata_q;
          wk_d    = 6'd1;
          cont    = dnsp_pkg::C_CHR;
        end
      end
      dnsp_pkg::OP_WALK_PTR: begin
        wt_d = {2'b00, wlen_q[5:0], rdata_q};
        cont = dnsp_pkg::C_WALK;
      end
      dnsp_pkg::OP_CHR: begin
        rd_en = 1'b1;
        raddr = AW'(wt_q + 16'(wk_q));
        cont  = dnsp_pkg::C_CHR_DATA;
      end
      dnsp_pkg::OP_CHR_DATA: begin
        if (!ac_ok) begin
          do_err   = 1'b1;
          err_code = E_TOO_LONG;
        end else begin
          do_add = 1'b1;
          add_c  = rdata_q;
          if (wk_q == wlen_q[5:0]) begin
            wt_d = wt_q + 16'(wlen_q) + 16'd1;
            cont = dnsp_pkg::C_WALK;
          end else begin
            wk_d = wk_q + 6'd1;
            cont = dnsp_pkg::C_CHR;
          end
        end
      end
      dnsp_pkg::OP_EOM: begin
        r.ans = 1'b0;
        r.idx = '0;
        if (phase_q == PH_FINISHED) begin
          want   = 1'b1;
          r.kind = K_DONE;
        end else if (phase_q != PH_ERROR) begin
          want   = 1'b1;
          r.kind = K_ERROR;
          r.err  = E_TRUNC;
        end
        pos_d = '0; phase_d = '0; acc_d = '0; ql_d = '0; al_d = '0; cur_d = '0;
        lbl_d = '0; nl_d = '0; first_d = 1'b1; phh_d = '0; dbl_d = '0;
        chunk_d = '0; fill_d = '0;
      end
      default: ;
    endcase

    if (do_add) begin
      for (int i = 0; i < 8; i++) begin
        if (fill_q == 4'(i)) nb[63-8*i -: 8] = add_c;
      end
      nf   = fill_q + 4'd1;
      nl_d = nl_q + 8'd1;
      if (nf >= 4'(dnsp_pkg::CHUNK_CHARS)) begin
        want    = 1'b1;
        r.kind  = K_CHUNK;
        r.value = nb;
        r.chars = nf;
        chunk_d = '0;
        fill_d  = '0;
      end else begin
        chunk_d = nb;
        fill_d  = nf;
      end
    end

    if (do_flush && fill_q != 4'd0) begin
      want    = 1'b1;
      r.kind  = K_CHUNK;
      r.value = chunk_q;
      r.chars = fill_q;
      chunk_d = '0;
      fill_d  = '0;
    end

    if (do_err) begin
      want    = 1'b1;
      r       = '0;
      r.kind  = K_ERROR;
      r.err   = err_code;
      phase_d = PH_ERROR;
      cont    = dnsp_pkg::C_DONE;
    end

    if (do_end) begin
      if (ql_q != 16'd0) begin
        ql_d  = ql_q - 16'd1;
        cur_d = (ql_q == 16'd1) ? 16'd0 : cur_q + 16'd1;
      end else begin
        if (al_q != 16'd0) al_d = al_q - 16'd1;
        cur_d = cur_q + 16'd1;
      end
      do_start = 1'b1;
    end

    if (do_start) begin
      if (ql_d == 16'd0 && al_d == 16'd0) begin
        phase_d = PH_FINISHED;
      end else begin
        nl_d = '0; first_d = 1'b1; chunk_d = '0; fill_d = '0; lbl_d = '0;
        phase_d = PH_NAME;
      end
    end

    if (cmd_i.op == dnsp_pkg::OP_PARSE && phase_q >= PH_FINISHED) begin
      want    = 1'b0;
      phase_d = phase_q;
    end

    push_o = want && (cnt_q < 6'(dnsp_pkg::MAX_RESULTS));
    if (push_o) cnt_d = cnt_q + 6'd1;
  end

  assign res_o           = r;
  assign status_o.cont   = cont;
  assign status_o.eom    = eom_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == dnsp_pkg::OP_LOAD && pos_q < PW'(MESSAGE_BYTES)) begin
      mem[pos_q[AW-1:0]] <= data_byte_i;
    end
    if (rd_en) rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0; sb_q <= '0; wlim_q <= '0; phase_q <= '0; acc_q <= '0;
      ql_q <= '0; al_q <= '0; cur_q <= '0; dbl_q <= '0; lbl_q <= '0;
      nl_q <= '0; byte_q <= '0; wlen_q <= '0; first_q <= 1'b1; eom_q <= 1'b0;
      phh_q <= '0; wk_q <= '0; cnt_q <= '0; chunk_q <= '0; fill_q <= '0;
      wt_q <= '0; hops_q <= '0;
    end else begin
      pos_q <= pos_d; sb_q <= sb_d; wlim_q <= wlim_d; phase_q <= phase_d; acc_q <= acc_d;
      ql_q <= ql_d; al_q <= al_d; cur_q <= cur_d; dbl_q <= dbl_d; lbl_q <= lbl_d;
      nl_q <= nl_d; byte_q <= byte_d; wlen_q <= wlen_d; first_q <= first_d; eom_q <= eom_d;
      phh_q <= phh_d; wk_q <= wk_d; cnt_q <= cnt_d; chunk_q <= chunk_d; fill_q <= fill_d;
      wt_q <= wt_d; hops_q <= hops_d;
    end
  end

  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q < 4'(dnsp_pkg::CHUNK_CHARS)) else $error("chunk overfilled");
  a_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PW'(MESSAGE_BYTES)) else $error("byte position overran memory");
  a_hops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hops_q <= 7'(dnsp_pkg::HOP_LIMIT)) else $error("hop count over limit");

endmodule

`default_nettype wire

>>> rtl/dns_response_parser.sv
// DNS response parser, top level.
// Instantiates dnsp_ctrl, dnsp_dp and dnsp_out; uses dnsp_pkg.
//
// The input channel takes one message byte per word, with end_of_message_i
// set on the last byte of a datagram. The output channel gives tagged fields
// (header values, name chunks, record fields, done or error), one per word;
// last_of_item_o marks the final word caused by an input byte.
// Each byte passes through an accept step, a parse step and a close step that
// hands the held word to the output register. A header flags word adds a step
// per flag field and the end of a name adds a step. A compression pointer adds
// walk steps per label and per pointer hop, and a read and a data step per character
// read from the single-port message memory, and the end of a message adds a step.
// Each word is held as the pending word until the next word or the close step,
// so that the last word of a byte can be marked.
// Reset clears all parse state; the message memory is not cleared and is only
// read at positions already written in the current message.
// When the receiver stalls, parsing stops once the result stage is full, and
// no new byte is taken until all words of the current byte are handed on.
`default_nettype none

module dns_response_parser #(
  parameter int MESSAGE_BYTES = 512
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        end_of_message_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [4:0]       kind_o,
  output logic [63:0]      value_o,
  output logic [3:0]       char_count_o,
  output logic             in_answer_o,
  output logic [15:0]      record_index_o,
  output logic [1:0]       error_code_o,
  output logic             last_of_item_o
);

  dnsp_pkg::cmd_t    cmd;
  dnsp_pkg::status_t status;
  dnsp_pkg::res_t    res;
  dnsp_pkg::res_t    out_res;
  logic              push;
  logic              can_push;
  logic              pend_v;
  logic              close;

  dnsp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .can_push_i (can_push),
    .pend_v_i   (pend_v),
    .status_i   (status),
    .cmd_o      (cmd),
    .close_o    (close)
  );

  dnsp_dp #(
    .MESSAGE_BYTES (MESSAGE_BYTES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .data_byte_i      (data_byte_i),
    .end_of_message_i (end_of_message_i),
    .status_o         (status),
    .push_o           (push),
    .res_o            (res)
  );

  dnsp_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .res_i       (res),
    .close_i     (close),
    .can_push_o  (can_push),
    .pend_v_o    (pend_v),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_o   (out_res),
    .out_last_o  (last_of_item_o)
  );

  assign kind_o         = out_res.kind;
  assign value_o        = out_res.value;
  assign char_count_o   = out_res.chars;
  assign in_answer_o    = out_res.ans;
  assign record_index_o = out_res.idx;
  assign error_code_o   = out_res.err;

endmodule

`default_nettype wire
